// ----- sv/gsrd_pkg.sv -----
package gsrd_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_READ    = 2'd1,
    FUNC_COMPUTE = 2'd2,
    FUNC_COMMIT  = 2'd3
  } func_t;

  localparam logic [2:0] REG_FEED  = 3'd0;
  localparam logic [2:0] REG_KILL  = 3'd1;
  localparam logic [2:0] REG_DIFFU = 3'd2;
  localparam logic [2:0] REG_DIFFV = 3'd3;
  localparam logic [2:0] REG_DT    = 3'd4;

  localparam logic [15:0] FEED_RST  = 16'd3604;
  localparam logic [15:0] KILL_RST  = 16'd4063;
  localparam logic [15:0] DIFFU_RST = 16'd16384;
  localparam logic [15:0] DIFFV_RST = 16'd8192;
  localparam logic [15:0] DT_RST    = 16'd4096;

endpackage

// ----- sv/gray_scott_reaction_diffusion_step_top.sv -----
// Gray-Scott reaction-diffusion cell engine on a wrap-around grid.
// Input channel (in_valid/in_ready) carries one request: func, cell_x,
// cell_y, conc_u_in, conc_v_in. Output channel (out_valid/out_ready)
// returns one result per request: conc_u_out, conc_v_out.
// Write stores into the front grid; read returns front values; compute
// runs the 5-point Laplacian and the update, writing the back grid;
// commit swaps the grids and returns zeros.
// A front stage accepts requests into a two-entry queue; a back
// sequencer executes them against single-read-port grid memories.
// Compute performs five memory reads, then five arithmetic steps.
// The back sequencer takes one request at a time and takes the next one
// the cycle after its result leaves.
// Reset clears the queue, selects bank a as front and loads the default
// rates. Grid contents are undefined until written.
// When the receiver stalls, the result holds and the back stops; the
// queue keeps taking up to two more requests.
// Write configuration only while idle.
module gray_scott_reaction_diffusion_step_top #(
  parameter int GRID_W = 256,
  parameter int GRID_H = 256,
  parameter int CONC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           func,
  input  logic [7:0]           cell_x,
  input  logic [7:0]           cell_y,
  input  logic [15:0]          conc_u_in,
  input  logic [15:0]          conc_v_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          conc_u_out,
  output logic [15:0]          conc_v_out,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  localparam int XW = (GRID_W > 1) ? $clog2(GRID_W) : 1;
  localparam int YW = (GRID_H > 1) ? $clog2(GRID_H) : 1;

  logic [15:0] feed, kill, diff_u, diff_v, dt;
  logic q_valid, q_ready;
  logic [1:0] q_func;
  logic [XW-1:0] q_x;
  logic [YW-1:0] q_y;
  logic [CONC_BITS-1:0] q_u, q_v, res_u, res_v;

  // Hold rate registers; ignore unknown indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      feed <= gsrd_pkg::FEED_RST;
      kill <= gsrd_pkg::KILL_RST;
      diff_u <= gsrd_pkg::DIFFU_RST;
      diff_v <= gsrd_pkg::DIFFV_RST;
      dt <= gsrd_pkg::DT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gsrd_pkg::REG_FEED:  feed <= cfg_data;
        gsrd_pkg::REG_KILL:  kill <= cfg_data;
        gsrd_pkg::REG_DIFFU: diff_u <= cfg_data;
        gsrd_pkg::REG_DIFFV: diff_v <= cfg_data;
        gsrd_pkg::REG_DT:    dt <= cfg_data;
        default: ;
      endcase
    end
  end

  gsrd_front #(.GRID_W(GRID_W), .GRID_H(GRID_H), .CONC_BITS(CONC_BITS),
               .XW(XW), .YW(YW)) u_front (
    .clk, .rst, .in_valid, .in_ready, .func, .cell_x, .cell_y,
    .conc_u_in, .conc_v_in, .q_valid, .q_ready, .q_func, .q_x, .q_y,
    .q_u, .q_v
  );

  gsrd_back #(.GRID_W(GRID_W), .GRID_H(GRID_H), .CONC_BITS(CONC_BITS),
              .XW(XW), .YW(YW)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_func, .q_x, .q_y, .q_u, .q_v,
    .feed, .kill, .diff_u, .diff_v, .dt, .out_valid, .out_ready,
    .res_u, .res_v
  );

  assign conc_u_out = 16'(res_u);
  assign conc_v_out = 16'(res_v);
endmodule

// ----- sv/gsrd_front.sv -----
// Accept requests and hand them to the queue with the wrapped address.
module gsrd_front #(
  parameter int GRID_W = 256,
  parameter int GRID_H = 256,
  parameter int CONC_BITS = 16,
  parameter int XW = 8,
  parameter int YW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           func,
  input  logic [7:0]           cell_x,
  input  logic [7:0]           cell_y,
  input  logic [15:0]          conc_u_in,
  input  logic [15:0]          conc_v_in,
  output logic                 q_valid,
  input  logic                 q_ready,
  output logic [1:0]           q_func,
  output logic [XW-1:0]        q_x,
  output logic [YW-1:0]        q_y,
  output logic [CONC_BITS-1:0] q_u,
  output logic [CONC_BITS-1:0] q_v
);
  localparam int QW = 2 + XW + YW + 2 * CONC_BITS;
  logic [QW-1:0] mem [2];
  logic [1:0] cnt;
  logic       wp, rp;
  logic [XW-1:0] xw;
  logic [YW-1:0] yw;
  logic [CONC_BITS-1:0] ui, vi;
  logic push, pop;

  always_comb begin
    xw = XW'(32'(cell_x) % GRID_W);
    yw = YW'(32'(cell_y) % GRID_H);
    ui = CONC_BITS'(conc_u_in);
    vi = CONC_BITS'(conc_v_in);
  end

  assign in_ready = (cnt != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt != 2'd0);
  assign pop = q_valid && q_ready;
  assign {q_func, q_x, q_y, q_u, q_v} = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= {func, xw, yw, ui, vi};
    end
    if (rst) begin
      cnt <= 2'd0;
      wp <= 1'b0;
      rp <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue overflow");
  a_push: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> cnt == $past(cnt) + 2'd1) else $error("push lost");
  a_pop: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> cnt == $past(cnt) - 2'd1) else $error("pop lost");
endmodule

// ----- sv/gsrd_back.sv -----
// Sequencer: read center and four neighbors per grid, then update in stages.
module gsrd_back #(
  parameter int GRID_W = 256,
  parameter int GRID_H = 256,
  parameter int CONC_BITS = 16,
  parameter int XW = 8,
  parameter int YW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  logic [1:0]           q_func,
  input  logic [XW-1:0]        q_x,
  input  logic [YW-1:0]        q_y,
  input  logic [CONC_BITS-1:0] q_u,
  input  logic [CONC_BITS-1:0] q_v,
  input  logic [15:0]          feed,
  input  logic [15:0]          kill,
  input  logic [15:0]          diff_u,
  input  logic [15:0]          diff_v,
  input  logic [15:0]          dt,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CONC_BITS-1:0] res_u,
  output logic [CONC_BITS-1:0] res_v
);
  localparam int CELLS = GRID_W * GRID_H;
  localparam int AW = XW + YW;
  localparam int CF = CONC_BITS - 2;
  localparam int CW = CONC_BITS;
  localparam int SW = CW + 24;

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_RD2, S_RD3, S_RD4, S_RD5,
    S_M1, S_M2, S_M3, S_M4, S_M5, S_DONE
  } state_t;

  state_t state;
  logic [CW-1:0] mem_u [2][CELLS];
  logic [CW-1:0] mem_v [2][CELLS];
  logic front;
  logic [1:0] func;
  logic [XW-1:0] x;
  logic [YW-1:0] y;
  logic [AW-1:0] raddr;
  logic [CW-1:0] rdu, rdv;
  logic [CW-1:0] cu, cv;
  logic signed [CW+3:0] lapu, lapv;
  logic [CW+1:0] uv;
  logic [CW+3:0] uvv;
  logic signed [SW-1:0] du, dv;
  logic signed [SW-1:0] pa, pb;
  logic wr_en, wr_bank;
  logic [AW-1:0] waddr;
  logic [CW-1:0] wdu, wdv;

  function automatic logic signed [SW-1:0] smul(input logic signed [SW-1:0] a,
                                                input logic [16:0] b,
                                                input int s);
    logic [SW-1:0] mag;
    logic [SW+16:0] p;
    logic [SW-1:0] r;
    mag = a[SW-1] ? SW'(-a) : SW'(a);
    p = (SW+17)'(mag) * (SW+17)'(b);
    r = SW'(p >> s);
    return a[SW-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [CW-1:0] clampc(input logic signed [SW-1:0] a);
    if (a < 0) return '0;
    if (a > $signed(SW'({CW{1'b1}}))) return '1;
    return CW'(a);
  endfunction

  function automatic logic [AW-1:0] addr(input logic [XW-1:0] ax,
                                         input logic [YW-1:0] ay);
    return AW'(32'(ay) * GRID_W + 32'(ax));
  endfunction

  logic [XW-1:0] xl, xr;
  logic [YW-1:0] yu, yd;
  always_comb begin
    xl = (x == '0) ? XW'(GRID_W - 1) : x - XW'(1);
    xr = (32'(x) == GRID_W - 1) ? '0 : x + XW'(1);
    yu = (y == '0) ? YW'(GRID_H - 1) : y - YW'(1);
    yd = (32'(y) == GRID_H - 1) ? '0 : y + YW'(1);
    case (state)
      S_RD0:   raddr = addr(x, y);
      S_RD1:   raddr = addr(xl, y);
      S_RD2:   raddr = addr(xr, y);
      S_RD3:   raddr = addr(x, yu);
      S_RD4:   raddr = addr(x, yd);
      default: raddr = addr(x, y);
    endcase
  end

  assign q_ready = (state == S_IDLE) && !out_valid;

  // Memory: one write and one registered read per grid a cycle.
  always_ff @(posedge clk) begin
    rdu <= mem_u[front][raddr];
    rdv <= mem_v[front][raddr];
    if (wr_en) begin
      mem_u[wr_bank][waddr] <= wdu;
      mem_v[wr_bank][waddr] <= wdv;
    end
  end

  always_ff @(posedge clk) begin
    wr_en <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      front <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (q_valid && q_ready) begin
          func <= q_func;
          x <= q_x;
          y <= q_y;
          case (gsrd_pkg::func_t'(q_func))
            gsrd_pkg::FUNC_WRITE: begin
              wr_en <= 1'b1;
              wr_bank <= front;
              waddr <= addr(q_x, q_y);
              wdu <= q_u;
              wdv <= q_v;
              res_u <= q_u;
              res_v <= q_v;
              out_valid <= 1'b1;
            end
            gsrd_pkg::FUNC_COMMIT: begin
              front <= ~front;
              res_u <= '0;
              res_v <= '0;
              out_valid <= 1'b1;
            end
            default: state <= S_RD0;
          endcase
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          cu <= rdu;
          cv <= rdv;
          lapu <= '0;
          lapv <= '0;
          if (func == gsrd_pkg::FUNC_READ) begin
            res_u <= rdu;
            res_v <= rdv;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_RD2;
          end
        end
        S_RD2, S_RD3, S_RD4, S_RD5: begin
          lapu <= lapu + $signed((CW+4)'(rdu));
          lapv <= lapv + $signed((CW+4)'(rdv));
          state <= (state == S_RD5) ? S_M1 : state_t'(state + 4'd1);
        end
        S_M1: begin
          lapu <= lapu - $signed({2'b00, cu, 2'b00});
          lapv <= lapv - $signed({2'b00, cv, 2'b00});
          uv <= (CW+2)'(((2*CW)'(cu) * (2*CW)'(cv)) >> CF);
          state <= S_M2;
        end
        S_M2: begin
          uvv <= (CW+4)'(((2*CW+2)'(uv) * (2*CW+2)'(cv)) >> CF);
          pa <= smul(SW'(lapu), {1'b0, diff_u}, 14);
          pb <= smul(SW'(lapv), {1'b0, diff_v}, 14);
          state <= S_M3;
        end
        S_M3: begin
          du <= pa - $signed(SW'(uvv))
              + smul($signed(SW'(1) <<< CF) - $signed(SW'(cu)), {1'b0, feed}, 16);
          dv <= pb + $signed(SW'(uvv))
              - smul($signed(SW'(cv)), 17'(feed) + 17'(kill), 16);
          state <= S_M4;
        end
        S_M4: begin
          pa <= smul(du, {1'b0, dt}, 12);
          pb <= smul(dv, {1'b0, dt}, 12);
          state <= S_M5;
        end
        S_M5: begin
          res_u <= clampc($signed(SW'(cu)) + pa);
          res_v <= clampc($signed(SW'(cv)) + pb);
          wdu <= clampc($signed(SW'(cu)) + pa);
          wdv <= clampc($signed(SW'(cv)) + pb);
          wr_en <= 1'b1;
          wr_bank <= ~front;
          waddr <= addr(x, y);
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !q_ready) else $error("accepted while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(res_u))
    else $error("result dropped");
  a_bank: assert property (@(posedge clk) disable iff (rst)
    (wr_en && func == gsrd_pkg::FUNC_COMPUTE) |-> wr_bank != front)
    else $error("compute wrote front bank");
endmodule
